/* src/hqvg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqvg_pkg
// Word types, register indexes and corner tables shared by the heightmap quad
// vertex generator.
// ----------------------------------------------------------------------------
package hqvg_pkg;

    // Input word: either a height sample load or a quad request.
    typedef struct packed {
        logic               mode;
        logic [13:0]        sample_index;
        logic signed [15:0] sample_height;
        logic [6:0]         quad_x;
        logic [6:0]         quad_z;
    } in_word_t;

    // Output word: one vertex.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] normal_x;
        logic [14:0]        normal_y;
        logic signed [15:0] normal_z;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic               last_vertex;
    } out_word_t;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SPACING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN  = 2'd2;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_QUAD = 1'b1;

    // Corner offsets of the two triangles, bit k belongs to vertex k.
    localparam logic [5:0] CORNER_DX = 6'b011010;
    localparam logic [5:0] CORNER_DZ = 6'b110100;
    localparam logic [2:0] LAST_CORNER = 3'd5;

    // One in Q1.14.
    localparam logic [14:0] UNIT_ONE = 15'd16384;

endpackage

/* src/heightmap_quad_vertex_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_quad_vertex_generator
// Loads a square heightmap into a height RAM and turns quad requests into six
// vertices with position, central-difference unit normal and texture coords.
// ----------------------------------------------------------------------------
// A load word writes one height sample. A quad word is worked off vertex by
// vertex: each of its six vertices needs five RAM reads, three squarings, a
// 32-step square root and up to five 17-step divisions on one shared divider.
// No new input word is taken until the last vertex of a quad has been emitted.
// Reset sets grid_size to 128 and cell_spacing and height_gain to 256; the
// height RAM is not cleared and holds garbage until written.
module heightmap_quad_vertex_generator
    import hqvg_pkg::*;
#(
    parameter int MAX_SIDE = 128
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int SW  = $clog2(MAX_SIDE + 1);
    localparam int CW  = $clog2(MAX_SIDE);
    localparam int QCW = SW + 7;
    localparam int PDW = (CW + 26 > 33) ? CW + 26 : 33;
    localparam logic signed [PDW-1:0] POS_MAX = PDW'(64'sd2147483647);
    localparam logic signed [PDW-1:0] POS_MIN = PDW'(-64'sd2147483648);
    localparam logic [2:0] DIV_TEX_U = 3'd3;
    localparam logic [2:0] DIV_TEX_V = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_DIFF,
        S_SHIFT,
        S_SQ,
        S_SQRT,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_EMIT
    } state_t;

    state_t state_reg;

    logic [7:0]  grid_size_reg;
    logic [15:0] cell_spacing_reg;
    logic [15:0] height_gain_reg;

    logic [CW-1:0] qx_reg, qz_reg, vx_reg, vz_reg;
    logic [2:0]    vtx_reg;
    logic [2:0]    rd_cnt_reg;
    logic signed [32:0] hgt_reg [5];
    logic [CW+15:0] px_prod_reg, pz_prod_reg, ph_prod_reg;
    logic signed [31:0] pos_x_reg, pos_z_reg;
    logic [33:0] mag_reg [3];
    logic [29:0] sm_reg [3];
    logic        neg_a_reg, neg_c_reg;
    logic [1:0]  sq_cnt_reg;
    logic [59:0] sqp_reg;
    logic [61:0] sum_reg;
    logic [61:0] sq_v_reg;
    logic [62:0] sq_r_reg, sq_bit_reg;
    logic [30:0] len_reg;
    logic [2:0]  div_sel_reg;
    logic [47:0] div_rem_reg;
    logic [30:0] div_den_reg;
    logic [16:0] div_q_reg;
    logic [4:0]  div_bit_reg;
    logic [14:0] nq_reg [3];
    logic [16:0] tex_u_reg, tex_v_reg;
    logic        out_valid_reg;
    out_word_t   out_data_reg;

    // Effective grid size and derived limits.
    logic [SW-1:0] size_eff;
    logic [SW-1:0] quad_lim;
    logic [CW-1:0] coord_hi;

    always_comb
    begin
        if (grid_size_reg < 8'd2)
        begin
            size_eff = SW'(2);
        end
        else if (16'(grid_size_reg) > 16'(MAX_SIDE))
        begin
            size_eff = SW'(MAX_SIDE);
        end
        else
        begin
            size_eff = SW'(grid_size_reg);
        end
        quad_lim = size_eff - SW'(2);
        coord_hi = CW'(size_eff - SW'(1));
    end

    // Height RAM.
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;
    logic          in_acc;

    assign in_acc = in_valid && !in_stall;
    assign ram_we = in_acc && (in_data.mode == MODE_LOAD)
                    && (32'(in_data.sample_index) < STORE_DEPTH);

    hqvg_ram #(
        .WIDTH (16),
        .DEPTH (STORE_DEPTH)
    ) u_height_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(in_data.sample_index)),
        .wdata (in_data.sample_height),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Neighbor address for the read in progress: center, left, right, down, up.
    logic [CW-1:0]    nx, nz;
    logic [CW+SW:0]   addr_lin;

    always_comb
    begin
        nx = vx_reg;
        nz = vz_reg;
        case (rd_cnt_reg)
            3'd1: nx = (vx_reg == '0) ? vx_reg : vx_reg - CW'(1);
            3'd2: nx = (vx_reg == coord_hi) ? vx_reg : vx_reg + CW'(1);
            3'd3: nz = (vz_reg == '0) ? vz_reg : vz_reg - CW'(1);
            3'd4: nz = (vz_reg == coord_hi) ? vz_reg : vz_reg + CW'(1);
            default: ;
        endcase
        addr_lin  = (CW+SW+1)'(nz) * (CW+SW+1)'(size_eff) + (CW+SW+1)'(nx);
        ram_raddr = AW'(addr_lin);
    end

    // Scaled height of the word just read.
    logic signed [32:0] scaled_h;
    assign scaled_h = $signed(ram_rdata) * $signed({1'b0, height_gain_reg});

    // Differences and position before saturation.
    logic signed [33:0] diff_a, diff_c;
    logic signed [PDW-1:0] pdx, pdz;

    always_comb
    begin
        diff_a = 34'(hgt_reg[1]) - 34'(hgt_reg[2]);
        diff_c = 34'(hgt_reg[3]) - 34'(hgt_reg[4]);
        pdx = PDW'({1'b0, px_prod_reg, 8'b0}) - PDW'({1'b0, ph_prod_reg, 7'b0});
        pdz = PDW'({1'b0, pz_prod_reg, 8'b0}) - PDW'({1'b0, ph_prod_reg, 7'b0});
    end

    // Smallest right shift that brings the largest magnitude below 2^30.
    logic [33:0] mag_max;
    logic [2:0]  shamt;

    always_comb
    begin
        mag_max = mag_reg[0];
        if (mag_reg[1] > mag_max)
        begin
            mag_max = mag_reg[1];
        end
        if (mag_reg[2] > mag_max)
        begin
            mag_max = mag_reg[2];
        end
        shamt = 3'd4;
        for (int i = 4; i >= 0; i--)
        begin
            if ((mag_max >> i) < 34'h0_4000_0000)
            begin
                shamt = 3'(i);
            end
        end
    end

    // Squaring, square root step and divider step.
    logic [29:0] sq_in;
    logic [59:0] sq_prod;
    logic [62:0] sq_trial;
    logic [47:0] div_trial;
    logic        div_hit;
    logic [16:0] div_q_next;
    logic [14:0] q_clamped;

    always_comb
    begin
        case (sq_cnt_reg)
            2'd0:    sq_in = sm_reg[0];
            2'd1:    sq_in = sm_reg[1];
            2'd2:    sq_in = sm_reg[2];
            default: sq_in = '0;
        endcase
        sq_prod   = 60'(sq_in) * 60'(sq_in);
        sq_trial  = sq_r_reg + sq_bit_reg;
        div_trial = 48'(div_den_reg) << div_bit_reg;
        div_hit   = div_rem_reg >= div_trial;
        div_q_next = div_q_reg | (div_hit ? (17'd1 << div_bit_reg) : 17'd0);
        q_clamped = (div_q_next > 17'(UNIT_ONE)) ? UNIT_ONE : div_q_next[14:0];
    end

    logic emit_go;
    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            grid_size_reg    <= 8'd128;
            cell_spacing_reg <= 16'd256;
            height_gain_reg  <= 16'd256;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            qx_reg           <= '0;
            qz_reg           <= '0;
            vx_reg           <= '0;
            vz_reg           <= '0;
            vtx_reg          <= '0;
            rd_cnt_reg       <= '0;
            px_prod_reg      <= '0;
            pz_prod_reg      <= '0;
            ph_prod_reg      <= '0;
            pos_x_reg        <= '0;
            pos_z_reg        <= '0;
            neg_a_reg        <= 1'b0;
            neg_c_reg        <= 1'b0;
            sq_cnt_reg       <= '0;
            sqp_reg          <= '0;
            sum_reg          <= '0;
            sq_v_reg         <= '0;
            sq_r_reg         <= '0;
            sq_bit_reg       <= '0;
            len_reg          <= '0;
            div_sel_reg      <= '0;
            div_rem_reg      <= '0;
            div_den_reg      <= '0;
            div_q_reg        <= '0;
            div_bit_reg      <= '0;
            tex_u_reg        <= '0;
            tex_v_reg        <= '0;
            for (int i = 0; i < 5; i++)
            begin
                hgt_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= '0;
                sm_reg[i]  <= '0;
                nq_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GRID_SIZE:    grid_size_reg    <= cfg_data[7:0];
                    REG_CELL_SPACING: cell_spacing_reg <= cfg_data[15:0];
                    REG_HEIGHT_GAIN:  height_gain_reg  <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // The emit step reloads the output word itself.
            if (out_valid_reg && !out_stall && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc && (in_data.mode == MODE_QUAD))
                    begin
                        qx_reg  <= (QCW'(in_data.quad_x) > QCW'(quad_lim))
                                   ? CW'(quad_lim) : CW'(in_data.quad_x);
                        qz_reg  <= (QCW'(in_data.quad_z) > QCW'(quad_lim))
                                   ? CW'(quad_lim) : CW'(in_data.quad_z);
                        vtx_reg <= '0;
                        state_reg <= S_SETUP;
                    end
                end

                S_SETUP:
                begin
                    vx_reg     <= qx_reg + CW'(CORNER_DX[vtx_reg]);
                    vz_reg     <= qz_reg + CW'(CORNER_DZ[vtx_reg]);
                    rd_cnt_reg <= '0;
                    state_reg  <= S_READ;
                end

                S_READ:
                begin
                    if (rd_cnt_reg == 3'd0)
                    begin
                        px_prod_reg <= (CW+16)'(vx_reg) * (CW+16)'(cell_spacing_reg);
                        pz_prod_reg <= (CW+16)'(vz_reg) * (CW+16)'(cell_spacing_reg);
                        ph_prod_reg <= (CW+16)'(coord_hi) * (CW+16)'(cell_spacing_reg);
                    end
                    else
                    begin
                        hgt_reg[rd_cnt_reg - 3'd1] <= scaled_h;
                    end
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    if (rd_cnt_reg == 3'd5)
                    begin
                        state_reg <= S_DIFF;
                    end
                end

                S_DIFF:
                begin
                    neg_a_reg  <= diff_a[33];
                    neg_c_reg  <= diff_c[33];
                    mag_reg[0] <= diff_a[33] ? 34'(-diff_a) : 34'(diff_a);
                    mag_reg[1] <= 34'({cell_spacing_reg, 9'b0});
                    mag_reg[2] <= diff_c[33] ? 34'(-diff_c) : 34'(diff_c);
                    pos_x_reg  <= (pdx > POS_MAX) ? 32'sh7fff_ffff :
                                  (pdx < POS_MIN) ? 32'sh8000_0000 : 32'(pdx);
                    pos_z_reg  <= (pdz > POS_MAX) ? 32'sh7fff_ffff :
                                  (pdz < POS_MIN) ? 32'sh8000_0000 : 32'(pdz);
                    state_reg  <= S_SHIFT;
                end

                S_SHIFT:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sm_reg[i] <= 30'(mag_reg[i] >> shamt);
                    end
                    sum_reg    <= '0;
                    sq_cnt_reg <= '0;
                    state_reg  <= S_SQ;
                end

                S_SQ:
                begin
                    // The squarer output is registered before it is summed.
                    sqp_reg <= sq_prod;
                    if (sq_cnt_reg != 2'd0)
                    begin
                        sum_reg <= sum_reg + 62'(sqp_reg);
                    end
                    sq_cnt_reg <= sq_cnt_reg + 2'd1;
                    if (sq_cnt_reg == 2'd3)
                    begin
                        sq_v_reg   <= sum_reg + 62'(sqp_reg);
                        sq_r_reg   <= '0;
                        sq_bit_reg <= 63'(1) << 62;
                        state_reg  <= S_SQRT;
                    end
                end

                S_SQRT:
                begin
                    if (sq_bit_reg == '0)
                    begin
                        len_reg <= sq_r_reg[30:0];
                        if (sq_r_reg == '0)
                        begin
                            nq_reg[0]   <= '0;
                            nq_reg[1]   <= UNIT_ONE;
                            nq_reg[2]   <= '0;
                            div_sel_reg <= DIV_TEX_U;
                        end
                        else
                        begin
                            div_sel_reg <= '0;
                        end
                        state_reg <= S_DIV_LOAD;
                    end
                    else
                    begin
                        if ({1'b0, sq_v_reg} >= sq_trial)
                        begin
                            sq_v_reg <= sq_v_reg - sq_trial[61:0];
                            sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                        end
                        else
                        begin
                            sq_r_reg <= sq_r_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                    end
                end

                S_DIV_LOAD:
                begin
                    if (div_sel_reg == DIV_TEX_U)
                    begin
                        div_rem_reg <= 48'({vx_reg, 16'b0}) + 48'(coord_hi >> 1);
                        div_den_reg <= 31'(coord_hi);
                    end
                    else if (div_sel_reg == DIV_TEX_V)
                    begin
                        div_rem_reg <= 48'({vz_reg, 16'b0}) + 48'(coord_hi >> 1);
                        div_den_reg <= 31'(coord_hi);
                    end
                    else
                    begin
                        div_rem_reg <= 48'({sm_reg[div_sel_reg[1:0]], 14'b0})
                                       + 48'(len_reg >> 1);
                        div_den_reg <= len_reg;
                    end
                    div_q_reg   <= '0;
                    div_bit_reg <= 5'd16;
                    state_reg   <= S_DIV_RUN;
                end

                S_DIV_RUN:
                begin
                    if (div_hit)
                    begin
                        div_rem_reg <= div_rem_reg - div_trial;
                    end
                    div_q_reg   <= div_q_next;
                    div_bit_reg <= div_bit_reg - 5'd1;
                    if (div_bit_reg == 5'd0)
                    begin
                        if (div_sel_reg == DIV_TEX_U)
                        begin
                            tex_u_reg <= div_q_next;
                        end
                        else if (div_sel_reg == DIV_TEX_V)
                        begin
                            tex_v_reg <= div_q_next;
                        end
                        else
                        begin
                            nq_reg[div_sel_reg[1:0]] <= q_clamped;
                        end
                        div_sel_reg <= div_sel_reg + 3'd1;
                        state_reg   <= (div_sel_reg == DIV_TEX_V) ? S_EMIT : S_DIV_LOAD;
                    end
                end

                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg             <= 1'b1;
                        out_data_reg.pos_x        <= pos_x_reg;
                        out_data_reg.pos_y        <= 32'(hgt_reg[0]);
                        out_data_reg.pos_z        <= pos_z_reg;
                        out_data_reg.normal_x     <= neg_a_reg ? -$signed({1'b0, nq_reg[0]})
                                                               : $signed({1'b0, nq_reg[0]});
                        out_data_reg.normal_y     <= nq_reg[1];
                        out_data_reg.normal_z     <= neg_c_reg ? -$signed({1'b0, nq_reg[2]})
                                                               : $signed({1'b0, nq_reg[2]});
                        out_data_reg.tex_u        <= tex_u_reg;
                        out_data_reg.tex_v        <= tex_v_reg;
                        out_data_reg.last_vertex  <= (vtx_reg == LAST_CORNER);
                        if (vtx_reg == LAST_CORNER)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            vtx_reg   <= vtx_reg + 3'd1;
                            state_reg <= S_SETUP;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A new vertex word only ever comes from the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("vertex word appeared outside the emit step");

    // The sixth corner of a quad is flagged as the last vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && vtx_reg == LAST_CORNER) |=> (out_valid && out_data.last_vertex))
        else $error("last vertex flag missing on sixth corner");

    // The divider never runs on a zero divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_RUN) |-> (div_den_reg != '0))
        else $error("divider started with zero divisor");

    // A quad request leaves the idle state on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_data.mode == MODE_QUAD) |=> (state_reg == S_SETUP))
        else $error("quad word did not start vertex generation");

endmodule

/* src/hqvg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hqvg_ram
// Simple dual-port RAM, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module hqvg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heightmap quad vertex generator. Heights are
// loaded, quads are requested under several register settings, and every
// vertex is compared field by field against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb;
    import hqvg_pkg::*;

    localparam int STORE_DEPTH = 128 * 128;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES = 900;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_word_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // Predictor state.
    logic signed [15:0] height_mem [STORE_DEPTH];
    bit                 sample_loaded [STORE_DEPTH];
    logic [7:0]         side_reg = 8'd128;
    logic [15:0]        spacing_reg = 16'd256;
    logic [15:0]        gain_reg = 16'd256;
    out_word_t          vertex_q [$];

    int  src_idle_pct = 0;
    int  sink_idle_pct = 0;
    int  words_sent = 0;
    int  idle_cycles = 0;
    bit  failed = 1'b0;

    heightmap_quad_vertex_generator #(.MAX_SIDE(128)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int side_eff();
        int s;
        s = side_reg;
        if (s < 2)
            s = 2;
        if (s > 128)
            s = 128;
        return s;
    endfunction

    function automatic int clamp_to(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint gained_height(int x, int z, int s);
        int idx;
        idx = clamp_to(z, s - 1) * s + clamp_to(x, s - 1);
        return longint'(height_mem[idx]) * longint'(gain_reg);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Magnitudes are scaled down until the largest fits in 30 bits, then each
    // is divided by the rounded-down length with half rounding up.
    function automatic void unit_normal(input longint a, input longint b, input longint c,
                                        output longint n [3]);
        longint          src [3];
        longint unsigned m [3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        int              sh;
        src[0] = a;
        src[1] = b;
        src[2] = c;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = src[i] < 0 ? longint'(-src[i]) : longint'(src[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        sh = 0;
        while (sh < 63 && (mx >> sh) >= (64'd1 << 30))
            sh++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] >>= sh;
            sum += m[i] * m[i];
        end
        len = int_sqrt(sum);
        if (len == 0)
        begin
            n[0] = 0;
            n[1] = 16384;
            n[2] = 0;
            return;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] * 16384 + len / 2) / len;
            if (q > 16384)
                q = 16384;
            n[i] = src[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic out_word_t vertex_at(int x, int z, int s, bit last);
        out_word_t v;
        longint    sp;
        longint    half;
        longint    den;
        longint    n [3];
        sp = spacing_reg;
        half = longint'(s - 1) * sp * 128;
        den = s - 1;
        unit_normal(gained_height(x - 1, z, s) - gained_height(x + 1, z, s), sp * 512,
                    gained_height(x, z - 1, s) - gained_height(x, z + 1, s), n);
        v.pos_x = sat32(longint'(x) * sp * 256 - half);
        v.pos_y = sat32(gained_height(x, z, s));
        v.pos_z = sat32(longint'(z) * sp * 256 - half);
        v.normal_x = n[0];
        v.normal_y = n[1];
        v.normal_z = n[2];
        v.tex_u = (longint'(x) * 65536 + den / 2) / den;
        v.tex_v = (longint'(z) * 65536 + den / 2) / den;
        v.last_vertex = last;
        return v;
    endfunction

    function automatic void update_model(in_word_t w);
        int s;
        int qx;
        int qz;
        if (w.mode == MODE_LOAD)
        begin
            height_mem[w.sample_index] = w.sample_height;
            sample_loaded[w.sample_index] = 1'b1;
            return;
        end
        s = side_eff();
        qx = clamp_to(w.quad_x, s - 2);
        qz = clamp_to(w.quad_z, s - 2);
        for (int k = 0; k < 6; k++)
            vertex_q.push_back(vertex_at(qx + CORNER_DX[k], qz + CORNER_DZ[k], s,
                                         k == LAST_CORNER));
    endfunction

    function automatic in_word_t load_word(int idx, logic [15:0] h);
        in_word_t w;
        w.mode = MODE_LOAD;
        w.sample_index = idx;
        w.sample_height = h;
        w.quad_x = $urandom_range(0, 127);
        w.quad_z = $urandom_range(0, 127);
        return w;
    endfunction

    function automatic in_word_t quad_word(int x, int z);
        in_word_t w;
        w.mode = MODE_QUAD;
        w.sample_index = $urandom_range(0, STORE_DEPTH - 1);
        w.sample_height = $urandom_range(0, 65535);
        w.quad_x = x;
        w.quad_z = z;
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        update_model(w);
        words_sent++;
    endtask

    task automatic send_load(int idx, logic [15:0] h);
        send_word(load_word(idx, h));
    endtask

    // Loads any height that the quad's stencil would read before it was written.
    task automatic send_quad(int x, int z);
        int s;
        int cx;
        int cz;
        int idx;
        int dx [5];
        int dz [5];
        dx = '{0, -1, 1, 0, 0};
        dz = '{0, 0, 0, -1, 1};
        s = side_eff();
        for (int k = 0; k < 6; k++)
        begin
            cx = clamp_to(x, s - 2) + CORNER_DX[k];
            cz = clamp_to(z, s - 2) + CORNER_DZ[k];
            for (int p = 0; p < 5; p++)
            begin
                idx = clamp_to(cz + dz[p], s - 1) * s + clamp_to(cx + dx[p], s - 1);
                if (!sample_loaded[idx])
                    send_load(idx, $urandom_range(0, 65535));
            end
        end
        send_word(quad_word(x, z));
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(int side, int spacing, int gain);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [31:0]          val [4];
        idx = '{REG_GRID_SIZE, REG_CELL_SPACING, REG_HEIGHT_GAIN, REG_UNUSED};
        val = '{side, spacing, gain, $urandom()};
        wait_results();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                REG_GRID_SIZE:    side_reg = val[i][7:0];
                REG_CELL_SPACING: spacing_reg = val[i][15:0];
                REG_HEIGHT_GAIN:  gain_reg = val[i][15:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_small_grid();
        apply_setting(2, 256, 256);
        send_load(0, 16'h8000);
        send_load(1, 16'h7FFF);
        send_load(2, 16'h0000);
        send_load(3, 16'hFFFF);
        send_quad(0, 0);
        // A coordinate past size-2 is clamped onto the last quad.
        send_quad(127, 127);
        send_load(STORE_DEPTH - 1, 16'h0001);
        apply_setting(3, 65535, 65535);
        send_quad(1, 0);
        send_quad(0, 1);
    endtask

    task automatic test_register_sweep();
        int settings [7][3];
        settings = '{'{0, 1, 65535}, '{1, 65535, 0}, '{255, 1, 65535}, '{128, 0, 0},
                     '{128, 256, 256}, '{128, 65535, 65535}, '{7, 0, 300}};
        foreach (settings[i])
        begin
            apply_setting(settings[i][0], settings[i][1], settings[i][2]);
            send_quad(0, 0);
            send_quad(127, 127);
            send_quad($urandom_range(0, 127), $urandom_range(0, 127));
        end
    endtask

    task automatic random_setting();
        int side;
        side = ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(2, 24);
        apply_setting(side, $urandom_range(1, 65535), $urandom_range(0, 65535));
    endtask

    task automatic test_random(int src_pct, int sink_pct, int count);
        int goal;
        int s;
        bit paused;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        goal = words_sent + count;
        paused = 1'b0;
        random_setting();
        while (words_sent < goal)
        begin
            s = side_eff();
            if (!paused && words_sent > goal - count / 2)
            begin
                paused = 1'b1;
                random_setting();
            end
            case ($urandom_range(0, 9))
                0, 1, 2:
                    send_quad($urandom_range(0, s - 2), $urandom_range(0, s - 2));
                3:
                    send_quad($urandom_range(0, 127), $urandom_range(0, 127));
                4, 5, 6:
                    send_load($urandom_range(0, s * s - 1), $urandom_range(0, 65535));
                default:
                    send_load($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 65535));
            endcase
        end
        wait_results();
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < sink_idle_pct);

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, want, got);
            failed = 1'b1;
        end
    endfunction

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (vertex_q.size() == 0)
            begin
                $display("%0t: unexpected vertex %h", $realtime, out_data);
                failed = 1'b1;
            end
            else
            begin
                want = vertex_q.pop_front();
                check_field("pos_x", want.pos_x, out_data.pos_x);
                check_field("pos_y", want.pos_y, out_data.pos_y);
                check_field("pos_z", want.pos_z, out_data.pos_z);
                check_field("normal_x", want.normal_x, out_data.normal_x);
                check_field("normal_y", want.normal_y, out_data.normal_y);
                check_field("normal_z", want.normal_z, out_data.normal_z);
                check_field("tex_u", want.tex_u, out_data.tex_u);
                check_field("tex_v", want.tex_v, out_data.tex_v);
                check_field("last_vertex", want.last_vertex, out_data.last_vertex);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        src_idle_pct = 38;
        sink_idle_pct = 64;
        test_small_grid();
        test_register_sweep();
        test_random(38, 64, 100);
        test_random(64, 38, 100);
        test_random(0, 0, 100);
        in_valid <= 1'b0;
        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
